// File: rtl/lgs_pkg.sv
// Shared types and constants for the Life generation step core.
// Used by the cell lane, the row unit and the top level.
package lgs_pkg;

    localparam int ROW_BITS      = 64;
    localparam int IDX_BITS      = 12;
    localparam int WIDTH_BITS    = 7;
    localparam int HEIGHT_BITS   = 13;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int OUT_DATA_BITS = 80;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 8'd1;

    localparam logic [WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 7'd64;
    localparam logic [HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 13'd64;

    // 3x3 window around one cell, bit 0 = left column, bit 2 = right column
    typedef struct packed {
        logic [2:0] above;
        logic [2:0] mid;
        logic [2:0] below;
    } nbhd_t;

    typedef struct packed {
        logic                last;
        logic [IDX_BITS-1:0] index;
        logic [ROW_BITS-1:0] cells;
    } result_t;

endpackage

// File: rtl/lgs_cell_lane.sv
// One cell lane: B3/S23 rule applied to a single 3x3 window.
// Depends on lgs_pkg (nbhd_t).
module lgs_cell_lane (
    input  lgs_pkg::nbhd_t win,
    output logic           next_alive
);
    import lgs_pkg::*;

    logic [3:0] count;

    always_comb
    begin
        count = 4'(win.above[0]) + 4'(win.above[1]) + 4'(win.above[2])
              + 4'(win.mid[0]) + 4'(win.mid[2])
              + 4'(win.below[0]) + 4'(win.below[1]) + 4'(win.below[2]);
        if (win.mid[1])
            next_alive = (count == 4'd2) || (count == 4'd3);
        else
            next_alive = (count == 4'd3);
    end

endmodule

// File: rtl/lgs_row_unit.sv
// Row unit: MAX_WIDTH cell lanes side by side, merged into one masked row.
// Depends on lgs_pkg and lgs_cell_lane.
module lgs_row_unit #(
    parameter int MAX_WIDTH = 64
) (
    input  logic [MAX_WIDTH-1:0] above,
    input  logic [MAX_WIDTH-1:0] mid,
    input  logic [MAX_WIDTH-1:0] below,
    input  logic [MAX_WIDTH-1:0] mask,
    output logic [MAX_WIDTH-1:0] next_row
);
    import lgs_pkg::*;

    logic [MAX_WIDTH+1:0] above_pad;
    logic [MAX_WIDTH+1:0] mid_pad;
    logic [MAX_WIDTH+1:0] below_pad;
    logic [MAX_WIDTH-1:0] lane_out;

    assign above_pad = {1'b0, above, 1'b0};
    assign mid_pad   = {1'b0, mid, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_lane
        nbhd_t win;
        assign win.above = above_pad[i+2:i];
        assign win.mid   = mid_pad[i+2:i];
        assign win.below = below_pad[i+2:i];

        lgs_cell_lane u_lane (
            .win        (win),
            .next_alive (lane_out[i])
        );
    end

    // columns past the configured width are dead
    assign next_row = lane_out & mask;

endmodule

// File: rtl/life_generation_step_core.sv
// Top level of the Life generation step core (B3/S23), one grid row per word.
// Depends on lgs_pkg and lgs_row_unit.
//
// Takes one input row per clock while s_axis_tready is high. Each row after the first of a
// frame yields the next generation of the row above it; the final row of a frame also yields
// its own, so it gives two words unless it is also the first. Results pass through a four-word
// queue; input is taken while at least two slots are free, so with the output always
// ready the block sustains one row per cycle. Rows above and below the frame are dead.
module life_generation_step_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lgs_pkg::ROW_BITS-1:0]       s_axis_tdata,  // [63:0] row_cells
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lgs_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // [63:0] next_row_cells,
                                                              // [75:64] row_index, pad
    output logic                               m_axis_tlast,  // last_row
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lgs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lgs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [WIDTH_BITS-1:0]  MAX_W  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] MAX_H  = HEIGHT_BITS'(MAX_HEIGHT);
    localparam logic [CNT_BITS-1:0]    ACCEPT_LIMIT = CNT_BITS'(DEPTH - 2);

    logic [WIDTH_BITS-1:0]  grid_width_reg;
    logic [HEIGHT_BITS-1:0] grid_height_reg;
    logic [MAX_WIDTH-1:0]   older_reg, older_next;
    logic [MAX_WIDTH-1:0]   previous_reg, previous_next;
    logic [IDX_BITS-1:0]    row_counter_reg, row_counter_next;

    result_t                fifo_mem_reg [DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]    fifo_count_reg, fifo_count_next;

    logic [WIDTH_BITS-1:0]  eff_w;
    logic [HEIGHT_BITS-1:0] eff_h;
    logic [MAX_WIDTH-1:0]   mask;
    logic [MAX_WIDTH-1:0]   cur;
    logic [MAX_WIDTH-1:0]   prev_m;
    logic [MAX_WIDTH-1:0]   older_m;
    logic [MAX_WIDTH-1:0]   above_last;
    logic [MAX_WIDTH-1:0]   row_a;
    logic [MAX_WIDTH-1:0]   row_b;
    logic                   first_row;
    logic                   row_last;
    logic                   in_fire;
    logic                   out_fire;
    logic                   push_a;
    logic                   push_b;
    logic [PTR_BITS-1:0]    wr_ptr_b;
    result_t                res_a;
    result_t                res_b;
    result_t                head;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = WIDTH_BITS'(1);
        else if (grid_width_reg > MAX_W)
            eff_w = MAX_W;
        else
            eff_w = grid_width_reg;

        if (grid_height_reg == '0)
            eff_h = HEIGHT_BITS'(1);
        else if (grid_height_reg > MAX_H)
            eff_h = MAX_H;
        else
            eff_h = grid_height_reg;

        for (int i = 0; i < MAX_WIDTH; i++)
            mask[i] = (WIDTH_BITS'(i) < eff_w);
    end

    // ---------------- row datapath ----------------
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign first_row = (row_counter_reg == '0);
    assign row_last  = ((HEIGHT_BITS'(row_counter_reg) + HEIGHT_BITS'(1)) >= eff_h);

    assign cur        = s_axis_tdata[MAX_WIDTH-1:0] & mask;
    assign prev_m     = previous_reg & mask;
    assign older_m    = first_row ? '0 : (older_reg & mask);
    assign above_last = first_row ? '0 : prev_m;

    lgs_row_unit #(.MAX_WIDTH(MAX_WIDTH)) u_row_above (
        .above    (older_m),
        .mid      (prev_m),
        .below    (cur),
        .mask     (mask),
        .next_row (row_a)
    );

    lgs_row_unit #(.MAX_WIDTH(MAX_WIDTH)) u_row_final (
        .above    (above_last),
        .mid      (cur),
        .below    ('0),
        .mask     (mask),
        .next_row (row_b)
    );

    always_comb
    begin
        res_a.cells = ROW_BITS'(row_a);
        res_a.index = row_counter_reg - IDX_BITS'(1);
        res_a.last  = 1'b0;
        res_b.cells = ROW_BITS'(row_b);
        res_b.index = row_counter_reg;
        res_b.last  = 1'b1;

        push_a = in_fire && !first_row;
        push_b = in_fire && row_last;

        if (row_last)
        begin
            older_next       = '0;
            previous_next    = '0;
            row_counter_next = '0;
        end
        else
        begin
            older_next       = above_last;
            previous_next    = cur;
            row_counter_next = row_counter_reg + IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg       <= '0;
            previous_reg    <= '0;
            row_counter_reg <= '0;
        end
        else if (in_fire)
        begin
            older_reg       <= older_next;
            previous_reg    <= previous_next;
            row_counter_reg <= row_counter_next;
        end
    end

    // ---------------- result queue ----------------
    assign wr_ptr_b = wr_ptr_reg + PTR_BITS'(push_a);

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg + PTR_BITS'(push_a) + PTR_BITS'(push_b);
        rd_ptr_next     = rd_ptr_reg + PTR_BITS'(out_fire);
        fifo_count_next = fifo_count_reg + CNT_BITS'(push_a) + CNT_BITS'(push_b)
                        - CNT_BITS'(out_fire);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            fifo_mem_reg[wr_ptr_reg] <= res_a;
        if (push_b)
            fifo_mem_reg[wr_ptr_b] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    assign head          = fifo_mem_reg[rd_ptr_reg];
    assign s_axis_tready = (fifo_count_reg <= ACCEPT_LIMIT);
    assign m_axis_tvalid = (fifo_count_reg != '0);
    assign m_axis_tdata  = OUT_DATA_BITS'({head.index, head.cells});
    assign m_axis_tlast  = head.last;

    // ---------------- assertions ----------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= CNT_BITS'(DEPTH))
        else $error("result queue overflow");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> fifo_count_reg <= ACCEPT_LIMIT)
        else $error("row accepted without room for two words");

    a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && first_row && !row_last) |=> fifo_count_reg <= $past(fifo_count_reg))
        else $error("first row of a frame produced a word");

endmodule

// File: sim/tb_top.sv
// Testbench for life_generation_step_core: streams grid rows in, checks every next-generation
// row word against a B3/S23 predictor kept alongside. Depends on lgs_pkg and the RTL core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int TALL_ROWS    = 300;
    localparam int PHASE_ITEMS  = 280;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = REG_GRID_HEIGHT + CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = '1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [ROW_BITS-1:0]      s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    life_generation_step_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [WIDTH_BITS-1:0]  grid_width_reg  = GRID_WIDTH_RESET;
    logic [HEIGHT_BITS-1:0] grid_height_reg = GRID_HEIGHT_RESET;
    logic [ROW_BITS-1:0]    row_two_up = '0;
    logic [ROW_BITS-1:0]    row_one_up = '0;
    logic [IDX_BITS-1:0]    frame_row  = '0;

    result_t expected_rows[$];

    int send_idle_pct = 28;
    int recv_idle_pct = 46;
    int mismatches    = 0;
    int hold_len      = 0;
    int hold_gen      = 0;

    function automatic int cells_in_use();
        if (grid_width_reg == 0) return 1;
        if (grid_width_reg > 64) return 64;
        return int'(grid_width_reg);
    endfunction

    function automatic int frame_rows();
        if (grid_height_reg == 0) return 1;
        if (grid_height_reg > 4096) return 4096;
        return int'(grid_height_reg);
    endfunction

    function automatic logic [ROW_BITS-1:0] live_mask();
        int w;
        w = cells_in_use();
        if (w >= 64) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic int cell_at(input logic [ROW_BITS-1:0] row, input int col);
        if (col < 0 || col > 63) return 0;
        return int'(row[col]);
    endfunction

    function automatic logic [ROW_BITS-1:0] life_next_row(input logic [ROW_BITS-1:0] above,
                                                         input logic [ROW_BITS-1:0] mid,
                                                         input logic [ROW_BITS-1:0] below);
        logic [ROW_BITS-1:0] res;
        int w;
        int n;
        res = '0;
        w = cells_in_use();
        for (int i = 0; i < w; i++) begin
            n = cell_at(above, i - 1) + cell_at(above, i) + cell_at(above, i + 1)
              + cell_at(mid, i - 1) + cell_at(mid, i + 1)
              + cell_at(below, i - 1) + cell_at(below, i) + cell_at(below, i + 1);
            if (mid[i]) res[i] = (n == 2 || n == 3);
            else        res[i] = (n == 3);
        end
        return res & live_mask();
    endfunction

    task automatic push_row(input logic [ROW_BITS-1:0] cells, input int idx, input logic last);
        result_t r;
        r.cells = cells;
        r.index = idx[IDX_BITS-1:0];
        r.last  = last;
        expected_rows.push_back(r);
    endtask

    task automatic predict_row(input logic [ROW_BITS-1:0] cells);
        logic [ROW_BITS-1:0] mask;
        logic [ROW_BITS-1:0] cur;
        logic [ROW_BITS-1:0] above;
        int h;
        int r;
        bit last;
        mask = live_mask();
        cur  = cells & mask;
        h    = frame_rows();
        r    = int'(frame_row);
        last = (r + 1 >= h);
        if (r == 0) row_two_up = '0;
        else        row_one_up &= mask;
        row_two_up &= mask;
        if (r > 0)
            push_row(life_next_row(row_two_up, row_one_up, cur), r - 1, 1'b0);
        if (last) begin
            above = (r > 0) ? row_one_up : '0;
            push_row(life_next_row(above, cur, '0), r, 1'b1);
            row_two_up = '0;
            row_one_up = '0;
            frame_row  = '0;
        end
        else begin
            row_two_up = (r > 0) ? row_one_up : '0;
            row_one_up = cur;
            frame_row  = frame_row + IDX_BITS'(1);
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_GRID_WIDTH)       grid_width_reg  = data[WIDTH_BITS-1:0];
        else if (idx == REG_GRID_HEIGHT) grid_height_reg = data[HEIGHT_BITS-1:0];
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // valid stays high across back-to-back words; only an idle gap or a drain lowers it
    task automatic send_row(input logic [ROW_BITS-1:0] cells);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cells;
        do @(posedge clk); while (!s_axis_tready);
        predict_row(cells);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ROW_BITS-1:0] random_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return a & b;
            2:       return a | b;
            default: return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_width_word();
        logic [8:0]            hi;
        logic [WIDTH_BITS-1:0] w;
        hi = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = 7'd64;
            2:       w = WIDTH_BITS'($urandom_range(65, 127));
            default: w = WIDTH_BITS'($urandom_range(1, 64));
        endcase
        return {hi, w};
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_height_word();
        logic [2:0]             hi;
        logic [HEIGHT_BITS-1:0] h;
        hi = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       h = '0;
            1:       h = HEIGHT_BITS'($urandom_range(4096, 8191));
            2, 3:    h = HEIGHT_BITS'($urandom_range(9, 40));
            default: h = HEIGHT_BITS'($urandom_range(1, 8));
        endcase
        return {hi, h};
    endfunction

    task automatic finish_frame();
        while (frame_row != 0) send_row(random_row());
        wait_drain();
    endtask

    // receiver: random idling, plus a long hold-off on request
    always @(negedge clk) begin : rx_drive
        int hold_seen;
        int hold_left;
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic note_mismatch(input string what, input logic [ROW_BITS-1:0] want,
                                 input logic [ROW_BITS-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
    endtask

    always @(posedge clk) begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rows.size() == 0) begin
                note_mismatch("unexpected word", '0, m_axis_tdata[63:0]);
            end
            else begin
                want = expected_rows.pop_front();
                if (m_axis_tdata[63:0] !== want.cells)
                    note_mismatch("next_row_cells", want.cells, m_axis_tdata[63:0]);
                if (m_axis_tdata[75:64] !== want.index)
                    note_mismatch("row_index", 64'(want.index), 64'(m_axis_tdata[75:64]));
                if (m_axis_tlast !== want.last)
                    note_mismatch("last_row", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // reset values, then a height cut below the current row
    task automatic test_reset_and_height_cut();
        send_row('1);
        send_row('0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_row(64'h5555_5555_5555_5555);
        wait_drain();
        write_reg(REG_GRID_HEIGHT, 16'd2);
        send_row('1);
        wait_drain();
    endtask

    task automatic test_single_row_frames();
        write_reg(REG_GRID_HEIGHT, 16'd1);
        send_row('1);
        send_row(64'h8000_0000_0000_0001);
        send_row(64'h0000_0007_0000_0000);
        wait_drain();
        write_reg(REG_GRID_HEIGHT, 16'd0);
        send_row(64'h0000_0000_0000_0007);
        send_row('1);
        wait_drain();
    endtask

    task automatic test_width_extremes();
        write_reg(REG_GRID_WIDTH, 16'd1);
        write_reg(REG_GRID_HEIGHT, 16'd3);
        repeat (3) send_row('1);
        wait_drain();
        write_reg(REG_GRID_WIDTH, 16'd0);
        write_reg(REG_GRID_HEIGHT, 16'd2);
        repeat (2) send_row('1);
        wait_drain();
        write_reg(REG_GRID_WIDTH, 16'hFFFF);
        write_reg(REG_GRID_HEIGHT, 16'd1);
        send_row('1);
        wait_drain();
    endtask

    task automatic test_ignored_index();
        write_reg(REG_UNUSED_LO, 16'd1);
        write_reg(REG_UNUSED_HI, 16'd0);
        send_row(64'hF0F0_0F0F_F0F0_0F0F);
        send_row('1);
        wait_drain();
    endtask

    task automatic test_blinker();
        write_reg(REG_GRID_WIDTH, 16'd5);
        write_reg(REG_GRID_HEIGHT, 16'd5);
        send_row(64'h0);
        repeat (3) send_row(64'h4);
        send_row(64'h0);
        wait_drain();
    endtask

    // output held off while rows keep coming, so the core must stall its input
    task automatic test_output_hold();
        finish_frame();
        write_reg(REG_GRID_WIDTH, 16'd16);
        write_reg(REG_GRID_HEIGHT, 16'd10);
        send_idle_pct = 0;
        hold_len = HOLD_CYCLES;
        hold_gen++;
        repeat (40) send_row(random_row());
        wait_drain();
    endtask

    // height clamped to the maximum, then cut below the current row
    task automatic test_tall_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        finish_frame();
        write_reg(REG_GRID_WIDTH, 16'hFFFF);
        write_reg(REG_GRID_HEIGHT, 16'hFFFF);
        repeat (TALL_ROWS) send_row(random_row());
        wait_drain();
        write_reg(REG_GRID_HEIGHT, 16'd1);
        send_row(random_row());
        wait_drain();
    endtask

    task automatic test_random_phase(input int s_pct, input int r_pct, input int items);
        int sent;
        int n;
        int h;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_WIDTH, random_width_word());
            if ($urandom_range(0, 3) != 0) write_reg(REG_GRID_HEIGHT, random_height_word());
            if ($urandom_range(0, 19) == 0)
                write_reg(CFG_IDX_BITS'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          CFG_DATA_BITS'($urandom_range(0, 65535)));
            h = frame_rows();
            n = $urandom_range(1, ((h > 16) ? 16 : h) * 3);
            repeat (n) send_row(random_row());
            sent += n;
            wait_drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_and_height_cut();
        test_single_row_frames();
        test_width_extremes();
        test_ignored_index();
        test_blinker();
        test_output_hold();
        test_tall_frame();
        test_random_phase(28, 46, PHASE_ITEMS);
        test_random_phase(46, 28, PHASE_ITEMS);
        test_random_phase(0, 0, PHASE_ITEMS);
        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lgs_pkg.sv
rtl/lgs_cell_lane.sv
rtl/lgs_row_unit.sv
rtl/life_generation_step_core.sv
sim/tb_top.sv
